// ===== rtl/multi_channel_virtual_rate_divider_assert.svh =====
// assertion macros for the rate divider rtl
`ifndef MULTI_CHANNEL_VIRTUAL_RATE_DIVIDER_ASSERT_SVH
`define MULTI_CHANNEL_VIRTUAL_RATE_DIVIDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MCVRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcvrd same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define MCVRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcvrd next-cycle check failed");

`endif

// ===== rtl/mcvrd_pkg.sv =====
// types and constants of the multi-channel rate divider
package mcvrd_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_OPEN = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;
  localparam logic [1:0] KIND_ARM  = 2'd3;

  localparam logic [7:0] ARG_BYTES = 8'd4;
  localparam int         MASK_W    = 3;
  localparam int         RATE_W    = 16;
  localparam int         SHIFT_W   = 4;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        channel;
    logic [RATE_W-1:0] rate_value;
    logic [7:0]        byte_count;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [MASK_W-1:0] fired_mask;
    logic [MASK_W-1:0] waiting_mask;
  } rsp_t;

  // decoded action for one item
  typedef struct packed {
    logic       tick;
    logic       load;
    logic       arm;
    logic [1:0] channel;
    logic       status;
  } cmd_t;

endpackage

// ===== rtl/multi_channel_virtual_rate_divider.sv =====
// path: request beat into the input register, then the result register, then response valid
// throughput: one item per cycle unless stalled; input stage refills in the cycle it drains
// a stalled response register holds the input stage, which then drops ready
// reset clears all valid bits and waiting flags and loads every counter and
// reload value with BASE_RATE / DEFAULT_RATE (at least one)
module multi_channel_virtual_rate_divider import mcvrd_pkg::*; #(
  parameter int CHANNELS     = 3,
  parameter int BASE_RATE    = 1024,
  parameter int DEFAULT_RATE = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  `include "multi_channel_virtual_rate_divider_assert.svh"

  localparam int CNT_W      = $clog2(BASE_RATE + 1);
  localparam int DEF_PERIOD = (BASE_RATE / DEFAULT_RATE < 1) ? 1 : BASE_RATE / DEFAULT_RATE;

  logic             pipe_valid;
  req_t             pipe_item;
  logic             advance;
  cmd_t             cmd;
  logic [CNT_W-1:0] period;
  logic [CHANNELS-1:0] fired;
  logic [CHANNELS-1:0] waiting_next;
  rsp_t             rsp_next;

  assign advance   = pipe_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !pipe_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (req_ready) begin
      pipe_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      pipe_item <= req;
    end
  end

  mcvrd_decode #(
    .CHANNELS   (CHANNELS),
    .BASE_RATE  (BASE_RATE),
    .CNT_W      (CNT_W),
    .DEF_PERIOD (DEF_PERIOD)
  ) u_decode (
    .item   (pipe_item),
    .cmd    (cmd),
    .period (period)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    mcvrd_channel #(
      .IDX        (c),
      .CNT_W      (CNT_W),
      .DEF_PERIOD (DEF_PERIOD)
    ) u_chan (
      .clk          (clk),
      .rst          (rst),
      .en           (advance),
      .cmd          (cmd),
      .period       (period),
      .fired        (fired[c]),
      .waiting_next (waiting_next[c])
    );
  end

  // only the low channels fit in the masks
  always_comb begin
    rsp_next        = '0;
    rsp_next.status = cmd.status;
    for (int c = 0; c < MASK_W; c++) begin
      if (c < CHANNELS) begin
        rsp_next.fired_mask[c]   = fired[c];
        rsp_next.waiting_mask[c] = waiting_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  `MCVRD_ASSERT_NOW(a_reject_no_fire, rsp_valid && rsp.status, rsp.fired_mask == '0)
  `MCVRD_ASSERT_NEXT(a_beat_fills_stage, req_valid && req_ready, pipe_valid)
  `MCVRD_ASSERT_NEXT(a_stage_holds, pipe_valid && !advance, pipe_valid && $stable(pipe_item))
  `MCVRD_ASSERT_NEXT(a_advance_gives_rsp, advance, rsp_valid)

endmodule

// ===== rtl/mcvrd_decode.sv =====
// item decode: argument checks and period computation
module mcvrd_decode import mcvrd_pkg::*; #(
  parameter int CHANNELS   = 3,
  parameter int BASE_RATE  = 1024,
  parameter int CNT_W      = 11,
  parameter int DEF_PERIOD = 512
) (
  input  req_t             item,
  output cmd_t             cmd,
  output logic [CNT_W-1:0] period
);

  localparam logic [CNT_W-1:0]  BASE_V = CNT_W'(BASE_RATE);
  localparam logic [CNT_W-1:0]  DEF_V  = CNT_W'(DEF_PERIOD);
  localparam logic [RATE_W:0]   BASE_W = (RATE_W+1)'(BASE_RATE);

  logic               chan_ok;
  logic               rate_ok;
  logic [SHIFT_W-1:0] shift;
  logic [CNT_W-1:0]   shifted;
  logic [CNT_W-1:0]   set_period;

  // rate is a power of two once checked, so the divide is a shift
  always_comb begin
    shift = '0;
    for (int i = 0; i < RATE_W; i++) begin
      if (item.rate_value[i]) begin
        shift = shift | SHIFT_W'(i);
      end
    end
  end

  assign shifted    = BASE_V >> shift;
  assign set_period = (shifted == '0) ? CNT_W'(1) : shifted;

  assign chan_ok = (int'(item.channel) < CHANNELS);
  assign rate_ok = (item.byte_count == ARG_BYTES) && (item.rate_value != '0) &&
                   ((item.rate_value & (item.rate_value - RATE_W'(1))) == '0) &&
                   ({1'b0, item.rate_value} <= BASE_W);

  always_comb begin
    cmd         = '0;
    cmd.channel = item.channel;
    period      = DEF_V;
    unique case (item.kind)
      KIND_TICK: begin
        cmd.tick = 1'b1;
      end
      KIND_OPEN: begin
        cmd.load   = chan_ok;
        cmd.status = chan_ok ? STATUS_OK : STATUS_REJECT;
      end
      KIND_SET: begin
        cmd.load   = chan_ok && rate_ok;
        cmd.status = (chan_ok && rate_ok) ? STATUS_OK : STATUS_REJECT;
        period     = set_period;
      end
      KIND_ARM: begin
        cmd.arm    = chan_ok;
        cmd.status = chan_ok ? STATUS_OK : STATUS_REJECT;
      end
      default: begin
        cmd.status = STATUS_REJECT;
      end
    endcase
  end

endmodule

// ===== rtl/mcvrd_channel.sv =====
// one virtual timer: down counter, reload value and waiting flag
module mcvrd_channel import mcvrd_pkg::*; #(
  parameter int IDX        = 0,
  parameter int CNT_W      = 11,
  parameter int DEF_PERIOD = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cmd_t             cmd,
  input  logic [CNT_W-1:0] period,
  output logic             fired,
  output logic             waiting_next
);

  localparam logic [CNT_W-1:0] DEF_V = CNT_W'(DEF_PERIOD);

  logic [CNT_W-1:0] counter;
  logic [CNT_W-1:0] counter_next;
  logic [CNT_W-1:0] reload;
  logic [CNT_W-1:0] reload_next;
  logic             waiting;
  logic             hit;

  assign hit   = (int'(cmd.channel) == IDX);
  assign fired = cmd.tick && (counter <= CNT_W'(1));

  always_comb begin
    counter_next = counter;
    reload_next  = reload;
    waiting_next = waiting;
    if (cmd.tick) begin
      if (fired) begin
        counter_next = reload;
        waiting_next = 1'b0;
      end else begin
        counter_next = counter - CNT_W'(1);
      end
    end else if (hit && cmd.load) begin
      reload_next  = period;
      counter_next = period;
    end else if (hit && cmd.arm) begin
      waiting_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= DEF_V;
      reload  <= DEF_V;
      waiting <= 1'b0;
    end else if (en) begin
      counter <= counter_next;
      reload  <= reload_next;
      waiting <= waiting_next;
    end
  end

endmodule

// ===== test/multi_channel_virtual_rate_divider_checker.sv =====
// response predictor and scoreboard for the multi-channel rate divider
`timescale 1ns / 100ps

module multi_channel_virtual_rate_divider_checker import mcvrd_pkg::*; #(
  parameter int CHANNELS     = 3,
  parameter int BASE_RATE    = 1024,
  parameter int DEFAULT_RATE = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   outstanding
);

  localparam int CNT_W = $clog2(BASE_RATE) + 1;
  typedef logic [CNT_W-1:0] count_t;

  count_t down_count   [CHANNELS];
  count_t reload_count [CHANNELS];
  logic   waiting      [CHANNELS];

  rsp_t expected_rsp_q[$];
  rsp_t want;
  int   rsp_index;

  function automatic count_t period_of(int rate);
    int p;
    p = (rate == 0) ? 1 : BASE_RATE / rate;
    // floor of one so a counter never rests at zero
    if (p == 0) p = 1;
    return count_t'(p);
  endfunction

  function automatic logic [MASK_W-1:0] waiting_bits();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int c = 0; c < CHANNELS && c < MASK_W; c++) begin
      if (waiting[c]) m[c] = 1'b1;
    end
    return m;
  endfunction

  // advances the shadow timers by one request and returns its response
  function automatic rsp_t predict_response(req_t item);
    rsp_t r;
    int   rate;
    r = '0;
    r.status = STATUS_OK;
    rate = int'(item.rate_value);
    if (item.kind == KIND_TICK) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (down_count[c] <= 1) begin
          down_count[c] = reload_count[c];
          waiting[c] = 1'b0;
          if (c < MASK_W) r.fired_mask[c] = 1'b1;
        end else begin
          down_count[c] = down_count[c] - count_t'(1);
        end
      end
    end else if (int'(item.channel) >= CHANNELS) begin
      r.status = STATUS_REJECT;
    end else if (item.kind == KIND_OPEN) begin
      reload_count[item.channel] = period_of(DEFAULT_RATE);
      down_count[item.channel] = reload_count[item.channel];
    end else if (item.kind == KIND_SET) begin
      if (item.byte_count != ARG_BYTES || rate == 0 || (rate & (rate - 1)) != 0 ||
          rate > BASE_RATE) begin
        r.status = STATUS_REJECT;
      end else begin
        reload_count[item.channel] = period_of(rate);
        down_count[item.channel] = reload_count[item.channel];
      end
    end else begin
      waiting[item.channel] = 1'b1;
    end
    r.waiting_mask = waiting_bits();
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        reload_count[c] = period_of(DEFAULT_RATE);
        down_count[c] = reload_count[c];
        waiting[c] = 1'b0;
      end
      expected_rsp_q.delete();
      rsp_index = 0;
      fail_count <= 0;
    end else begin
      // compare first: a response can never belong to a request in the same beat
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          if (fail_count < 10)
            $display("response %0d with none expected: status %0b fired %03b waiting %03b",
                     rsp_index, rsp.status, rsp.fired_mask, rsp.waiting_mask);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status || rsp.fired_mask !== want.fired_mask ||
              rsp.waiting_mask !== want.waiting_mask) begin
            if (fail_count < 10) begin
              $display("response %0d: expected status %0b fired %03b waiting %03b",
                       rsp_index, want.status, want.fired_mask, want.waiting_mask);
              $display("response %0d: got status %0b fired %03b waiting %03b",
                       rsp_index, rsp.status, rsp.fired_mask, rsp.waiting_mask);
            end
            fail_count <= fail_count + 1;
          end
        end
        rsp_index++;
      end
      if (req_valid && req_ready) expected_rsp_q.push_back(predict_response(req));
    end
    outstanding <= expected_rsp_q.size();
  end

endmodule

// ===== test/multi_channel_virtual_rate_divider_tb.sv =====
// stimulus, clock, reset and verdict for the multi-channel rate divider
`timescale 1ns / 100ps

module multi_channel_virtual_rate_divider_tb;
  import mcvrd_pkg::*;

  localparam int CHANNELS        = 3;
  localparam int BASE_RATE       = 1024;
  localparam int DEFAULT_RATE    = 2;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int outstanding;

  int tx_gap_max   = 13;
  int rx_gap_max   = 13;
  bit hold_off_req = 1'b0;

  always #10 clk = ~clk;

  multi_channel_virtual_rate_divider #(
    .CHANNELS    (CHANNELS),
    .BASE_RATE   (BASE_RATE),
    .DEFAULT_RATE(DEFAULT_RATE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  multi_channel_virtual_rate_divider_checker #(
    .CHANNELS    (CHANNELS),
    .BASE_RATE   (BASE_RATE),
    .DEFAULT_RATE(DEFAULT_RATE)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  function automatic req_t make_req(logic [1:0] kind, logic [1:0] channel,
                                    logic [15:0] rate, logic [7:0] bytes);
    req_t r;
    r.kind = kind;
    r.channel = channel;
    r.rate_value = rate;
    r.byte_count = bytes;
    return r;
  endfunction

  // mostly well-formed traffic with some noise and broken set-rate beats
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(99, 0);
    r.channel = ($urandom_range(9, 0) == 0) ? 2'd3 : 2'($urandom_range(2, 0));
    r.rate_value = 16'($urandom);
    r.byte_count = 8'($urandom);
    if (pick < 45) begin
      r.kind = KIND_TICK;
    end else if (pick < 65) begin
      r.kind = KIND_SET;
      // lean towards short periods so channels fire often
      if ($urandom_range(3, 0) == 0) r.rate_value = 16'(1 << $urandom_range(10, 0));
      else r.rate_value = 16'(1 << $urandom_range(10, 4));
      r.byte_count = ARG_BYTES;
    end else if (pick < 72) begin
      r.kind = KIND_SET;
      case ($urandom_range(3, 0))
        0: begin
          r.rate_value = 16'(1 << $urandom_range(15, 11));
          r.byte_count = ARG_BYTES;
        end
        1: r.rate_value = 16'(1 << $urandom_range(10, 0));
        2: r.byte_count = ARG_BYTES;
        default: begin
          r.rate_value = '0;
          r.byte_count = ARG_BYTES;
        end
      endcase
    end else if (pick < 87) begin
      r.kind = KIND_ARM;
    end else begin
      r.kind = KIND_OPEN;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input req_t item);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_beat(random_request());
  endtask

  // receiver: random gaps, plus one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      gap = $urandom_range(rx_gap_max, 0);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(make_req(KIND_TICK, 2'd0, 16'hffff, 8'hff));
    send_beat(make_req(KIND_ARM, 2'd0, 16'd0, 8'd0));
    send_beat(make_req(KIND_ARM, 2'd1, 16'd0, 8'd0));
    send_beat(make_req(KIND_ARM, 2'd2, 16'd0, 8'd0));
    send_beat(make_req(KIND_ARM, 2'd3, 16'd0, 8'd0));
    // period of one: the counter sits at one and fires on every tick
    send_beat(make_req(KIND_SET, 2'd0, 16'd1024, ARG_BYTES));
    send_beat(make_req(KIND_TICK, 2'd0, 16'd0, 8'd0));
    send_beat(make_req(KIND_TICK, 2'd3, 16'd0, 8'd0));
    send_beat(make_req(KIND_SET, 2'd1, 16'd1, ARG_BYTES));
    send_beat(make_req(KIND_SET, 2'd2, 16'd0, ARG_BYTES));
    send_beat(make_req(KIND_SET, 2'd2, 16'd3, ARG_BYTES));
    send_beat(make_req(KIND_SET, 2'd2, 16'd2048, ARG_BYTES));
    send_beat(make_req(KIND_SET, 2'd2, 16'hffff, 8'hff));
    send_beat(make_req(KIND_SET, 2'd2, 16'd512, 8'd0));
    send_beat(make_req(KIND_SET, 2'd2, 16'd512, 8'hff));
    send_beat(make_req(KIND_SET, 2'd2, 16'd512, 8'd5));
    send_beat(make_req(KIND_SET, 2'd2, 16'd512, 8'd3));
    send_beat(make_req(KIND_SET, 2'd2, 16'd512, ARG_BYTES));
    send_beat(make_req(KIND_SET, 2'd3, 16'd512, ARG_BYTES));
    send_beat(make_req(KIND_OPEN, 2'd0, 16'd0, 8'd0));
    send_beat(make_req(KIND_OPEN, 2'd3, 16'd0, 8'd0));
    send_beat(make_req(KIND_TICK, 2'd0, 16'd0, 8'd0));
    send_beat(make_req(KIND_TICK, 2'd0, 16'd0, 8'd0));
    send_beat(make_req(KIND_TICK, 2'd0, 16'd0, 8'd0));
    send_beat(make_req(KIND_SET, 2'd0, 16'd32768, ARG_BYTES));

    send_random(400);

    tx_gap_max = 0;
    rx_gap_max = 0;
    send_random(250);

    // receiver stalls for a long stretch while requests keep coming
    rx_gap_max = 3;
    hold_off_req = 1'b1;
    send_random(200);

    tx_gap_max = 13;
    rx_gap_max = 0;
    send_random(150);

    tx_gap_max = 0;
    rx_gap_max = 13;
    send_random(200);

    req_valid <= 1'b0;
    while (outstanding != 0 || hold_off_req) @(negedge clk);
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
